@@ design/brb_pkg.sv @@
`timescale 1ns / 1ps

package brb_pkg;

  // Fixed field widths
  localparam int CNT_W  = 11;  // capacity, fill level
  localparam int LEN_W  = 7;   // burst length
  localparam int BYTE_W = 8;

  // Defaults for top-level parameters
  localparam int DEPTH_DEF     = 1024;
  localparam int MAX_BURST_DEF = 64;

  // Capacity after reset
  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Clamp a capacity value into 1..depth
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] v, input int depth);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > depth) begin
      r = CNT_W'(depth);
    end
    return r;
  endfunction

endpackage

@@ design/brb_ram.sv @@
`timescale 1ns / 1ps

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/brb_mod.sv @@
`timescale 1ns / 1ps

// Restoring remainder unit: one dividend bit per cycle.
module brb_mod #(
  parameter int DW = 13,
  parameter int RW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [RW-1:0] divisor,
  output logic          done,
  output logic [RW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dvd;
  logic [RW-1:0] div_q;
  logic [RW:0]   trial;

  // Shift in the next dividend bit and subtract if it fits
  assign trial = {remainder, dvd[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(DW);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      div_q     <= divisor;
      remainder <= '0;
    end else if (run) begin
      dvd <= dvd << 1;
      if (trial >= {1'b0, div_q}) begin
        remainder <= RW'(trial - {1'b0, div_q});
      end else begin
        remainder <= RW'(trial);
      end
    end
  end

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    done |-> (remainder < div_q))
    else $error("remainder not below divisor");

endmodule

@@ design/byte_ring_buffer.sv @@
`timescale 1ns / 1ps

// Byte ring buffer. A byte of a dropped write burst, a byte of an open write burst whose address
// is still valid, an empty request or a rejected read gives its result the cycle after transfer;
// the next item may follow at once. Any other accepted write byte (an opening byte, or one after
// a capacity write) first runs the address remainder unit, then gives its result. A read of n
// bytes runs the same unit, then streams one byte per cycle; busy holds items off in both cases.
// The receiver cannot stall and takes each result in its strobe cycle. Reset: synchronous,
// clears read pointer, fill and burst state, capacity to 1024 (at most DEPTH); store kept.
module byte_ring_buffer import brb_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              op,
  input  logic [LEN_W-1:0]  burst_len,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  capacity,
  output logic              done,
  output logic              status,
  output logic              has_data,
  output logic [BYTE_W-1:0] read_byte,
  output logic              last,
  output logic [CNT_W-1:0]  fill_level
);

  localparam int AW    = $clog2(DEPTH);
  localparam int SUM_W = ((AW > CNT_W) ? AW : CNT_W) + 2;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MOD_W = 2'd1;
  localparam logic [1:0] S_MOD_R = 2'd2;
  localparam logic [1:0] S_READ  = 2'd3;

  // Registers
  logic [1:0]        state, state_next;
  logic [CNT_W-1:0]  cap;
  logic [AW-1:0]     rp, rp_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic [LEN_W-1:0]  burst_rem, burst_rem_next;
  logic [LEN_W-1:0]  off, off_next;
  logic              rej, rej_next;
  logic [CNT_W-1:0]  ptr, ptr_next;
  logic              addr_ok, addr_ok_next;
  logic [BYTE_W-1:0] wdata_q, wdata_q_next;
  logic [LEN_W-1:0]  rd_len, rd_len_next;
  logic [LEN_W-1:0]  k, k_next;
  logic              done_next, status_next, has_data_next, last_next;
  logic [CNT_W-1:0]  fill_level_next;

  // Remainder unit
  logic             mod_start;
  logic [SUM_W-1:0] mod_dvd;
  logic             mod_done;
  logic [CNT_W-1:0] mod_rem;

  // Store ports
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  // Write step inputs
  logic              ws_go;
  logic [CNT_W-1:0]  ws_addr;
  logic [BYTE_W-1:0] ws_data;
  logic [LEN_W-1:0]  ws_rem;
  logic              ws_rej;
  logic [LEN_W-1:0]  ws_off;
  logic [LEN_W-1:0]  ws_rem_dec;
  logic [SUM_W-1:0]  ws_addr_ext;

  logic              accept, opening, byte_item;
  logic              new_rej;
  logic [LEN_W-1:0]  cur_rem, cur_off;
  logic              cur_rej;
  logic [SUM_W-1:0]  ptr_inc_ext, ptr_ext;
  logic [SUM_W-1:0]  base_wr;

  function automatic logic [CNT_W-1:0] wrap_inc(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] c);
    logic [CNT_W:0] s;
    s = {1'b0, a} + (CNT_W+1)'(1);
    return (s == {1'b0, c}) ? '0 : CNT_W'(s);
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign read_byte = has_data ? ram_rdata : '0;

  // Item classification
  assign opening   = (burst_rem == '0) && (burst_len != '0) && (op == OP_WRITE);
  assign byte_item = opening || (burst_rem != '0);
  assign new_rej   = (burst_len > LEN_W'(MAX_BURST)) ||
                     (({1'b0, fill} + (CNT_W+1)'(burst_len)) > {1'b0, cap});
  assign cur_rem   = opening ? burst_len : burst_rem;
  assign cur_rej   = opening ? new_rej : rej;
  assign cur_off   = opening ? '0 : off;
  assign base_wr   = SUM_W'(rp) + SUM_W'(fill) + SUM_W'(cur_off);
  assign ptr_ext     = SUM_W'(ptr);
  assign ptr_inc_ext = SUM_W'(wrap_inc(ptr, cap));
  assign ws_addr_ext = SUM_W'(ws_addr);
  assign ws_rem_dec  = ws_rem - LEN_W'(1);

  brb_mod #(
    .DW(SUM_W),
    .RW(CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (cap),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  brb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Control and next state
  always_comb begin
    state_next      = state;
    rp_next         = rp;
    fill_next       = fill;
    burst_rem_next  = burst_rem;
    off_next        = off;
    rej_next        = rej;
    ptr_next        = ptr;
    addr_ok_next    = addr_ok;
    wdata_q_next    = wdata_q;
    rd_len_next     = rd_len;
    k_next          = k;
    done_next       = 1'b0;
    status_next     = status;
    has_data_next   = 1'b0;
    last_next       = last;
    fill_level_next = fill_level;
    mod_start       = 1'b0;
    mod_dvd         = base_wr;
    ram_we          = 1'b0;
    ram_waddr       = ws_addr_ext[AW-1:0];
    ram_wdata       = ws_data;
    ram_re          = 1'b0;
    ram_raddr       = ptr_ext[AW-1:0];
    ws_go           = 1'b0;
    ws_addr         = ptr;
    ws_data         = data_byte;
    ws_rem          = cur_rem;
    ws_rej          = cur_rej;
    ws_off          = cur_off;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (byte_item) begin
            if (!cur_rej && (opening || !addr_ok)) begin
              // need a fresh write address first
              burst_rem_next = cur_rem;
              rej_next       = cur_rej;
              off_next       = cur_off;
              wdata_q_next   = data_byte;
              mod_start      = 1'b1;
              state_next     = S_MOD_W;
            end else begin
              ws_go = 1'b1;
            end
          end else if (burst_len == '0) begin
            done_next       = 1'b1;
            status_next     = 1'b0;
            last_next       = 1'b1;
            fill_level_next = fill;
          end else if ((burst_len > LEN_W'(MAX_BURST)) ||
                       ({4'b0, burst_len} > fill)) begin
            done_next       = 1'b1;
            status_next     = 1'b1;
            last_next       = 1'b1;
            fill_level_next = fill;
          end else begin
            rd_len_next = burst_len;
            mod_dvd     = SUM_W'(rp);
            mod_start   = 1'b1;
            state_next  = S_MOD_R;
          end
        end
      end
      S_MOD_W: begin
        if (mod_done) begin
          ws_go      = 1'b1;
          ws_addr    = mod_rem;
          ws_data    = wdata_q;
          ws_rem     = burst_rem;
          ws_rej     = rej;
          ws_off     = off;
          state_next = S_IDLE;
        end
      end
      S_MOD_R: begin
        if (mod_done) begin
          ptr_next   = mod_rem;
          k_next     = '0;
          state_next = S_READ;
        end
      end
      S_READ: begin
        // issue one store read; its byte shows next cycle
        ram_re          = 1'b1;
        ptr_next        = wrap_inc(ptr, cap);
        k_next          = k + LEN_W'(1);
        done_next       = 1'b1;
        status_next     = 1'b0;
        has_data_next   = 1'b1;
        last_next       = (k + LEN_W'(1)) == rd_len;
        fill_level_next = fill - CNT_W'(k) - CNT_W'(1);
        if ((k + LEN_W'(1)) == rd_len) begin
          rp_next    = ptr_inc_ext[AW-1:0];
          fill_next  = fill - CNT_W'(rd_len);
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // One byte of an open write burst
    if (ws_go) begin
      ram_we          = !ws_rej;
      done_next       = 1'b1;
      status_next     = ws_rej;
      fill_level_next = fill;
      last_next       = (ws_rem_dec == '0);
      if (!ws_rej) begin
        ptr_next     = wrap_inc(ws_addr, cap);
        addr_ok_next = 1'b1;
      end
      if (ws_rem_dec == '0) begin
        if (!ws_rej) begin
          fill_next       = fill + CNT_W'(ws_off + LEN_W'(1));
          fill_level_next = fill + CNT_W'(ws_off + LEN_W'(1));
        end
        burst_rem_next = '0;
        off_next       = '0;
        rej_next       = 1'b0;
      end else begin
        burst_rem_next = ws_rem_dec;
        off_next       = ws_off + LEN_W'(1);
        rej_next       = ws_rej;
      end
    end

    // A capacity write invalidates the running write address
    if (cfg_valid && cfg_ready) begin
      addr_ok_next = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap       <= eff_cap(CAP_RESET, DEPTH);
      rp        <= '0;
      fill      <= '0;
      burst_rem <= '0;
      off       <= '0;
      rej       <= 1'b0;
      addr_ok   <= 1'b0;
      done      <= 1'b0;
      has_data  <= 1'b0;
    end else begin
      state     <= state_next;
      rp        <= rp_next;
      fill      <= fill_next;
      burst_rem <= burst_rem_next;
      off       <= off_next;
      rej       <= rej_next;
      addr_ok   <= addr_ok_next;
      done      <= done_next;
      has_data  <= has_data_next;
      if (cfg_valid && cfg_ready) begin
        cap <= eff_cap(capacity, DEPTH);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    wdata_q    <= wdata_q_next;
    rd_len     <= rd_len_next;
    k          <= k_next;
    status     <= status_next;
    last       <= last_next;
    fill_level <= fill_level_next;
  end

  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    (done && has_data) |-> !status)
    else $error("byte result flagged as rejected");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (ptr < cap))
    else $error("read address beyond capacity");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (k < rd_len))
    else $error("read count overran request");

  a_burst_clean: assert property (@(posedge clk) disable iff (rst)
    (burst_rem == '0) |-> (!rej && (off == '0)))
    else $error("burst state left over after burst end");

endmodule

@@ bench/brb_checker.sv @@
`timescale 1ns / 1ps

// Watches the item, config and result channels of the byte ring buffer, keeps
// a shadow of its state, and compares every result with the oldest one owed.
module brb_checker import brb_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic              op,
  input  logic [LEN_W-1:0]  burst_len,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CNT_W-1:0]  capacity,
  input  logic              done,
  input  logic              status,
  input  logic              has_data,
  input  logic [BYTE_W-1:0] read_byte,
  input  logic              last,
  input  logic [CNT_W-1:0]  fill_level,
  output int                mismatches,
  output int                outstanding,
  output int                results_seen,
  output int                bytes_read,
  output int                rejects_seen
);

  typedef struct packed {
    logic              status;
    logic              has_data;
    logic [BYTE_W-1:0] rbyte;
    logic              last;
    logic [CNT_W-1:0]  fill;
  } buf_result_t;

  // Results the buffer still owes, oldest first
  buf_result_t owed_results[$];

  // Shadow of the buffer state
  logic [BYTE_W-1:0] shadow_mem [DEPTH];
  int unsigned       rd_ptr;
  int unsigned       held;
  int unsigned       burst_left;
  int unsigned       burst_off;
  logic              burst_drop;
  logic [CNT_W-1:0]  cap_reg;

  // Capacity in use: zero acts as one, anything past the store acts as its size
  function automatic int unsigned usable_cap();
    if (cap_reg == '0) return 1;
    if (int'(cap_reg) > DEPTH) return DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic void owe(input logic st, input logic hd, input logic [BYTE_W-1:0] b,
                              input logic lst, input int unsigned fl);
    buf_result_t r;
    r.status   = st;
    r.has_data = hd;
    r.rbyte    = b;
    r.last     = lst;
    r.fill     = CNT_W'(fl);
    owed_results.push_back(r);
  endfunction

  // Work out the results of one accepted item and advance the shadow state
  function automatic void predict_buffer_item(input logic o, input logic [LEN_W-1:0] len,
                                              input logic [BYTE_W-1:0] d);
    int unsigned cap;
    int unsigned addr;
    int unsigned k;
    cap = usable_cap();
    if (burst_left == 0) begin
      // empty request of either kind: one plain result, nothing opened
      if (len == 0) begin
        owe(1'b0, 1'b0, '0, 1'b1, held);
        return;
      end
      if (o == OP_READ) begin
        if (len > MAX_BURST || len > held) begin
          owe(1'b1, 1'b0, '0, 1'b1, held);
          return;
        end
        for (k = 0; k < len; k++) begin
          addr = ((rd_ptr + k) % cap) % DEPTH;
          owe(1'b0, 1'b1, shadow_mem[addr], k + 1 == len, held - k - 1);
        end
        rd_ptr = (rd_ptr + len) % cap;
        held   = held - len;
        return;
      end
      // opening byte of a write burst
      burst_left = len;
      burst_off  = 0;
      burst_drop = (len > MAX_BURST) || (len + held > cap);
    end

    // one byte of the open burst; op and length are don't-care here
    if (!burst_drop) begin
      addr = ((rd_ptr + held + burst_off) % cap) % DEPTH;
      shadow_mem[addr] = d;
    end
    burst_off++;
    burst_left--;
    if (burst_left == 0) begin
      if (!burst_drop) held = held + burst_off;
      owe(burst_drop, 1'b0, '0, 1'b1, held);
      burst_off  = 0;
      burst_drop = 1'b0;
    end else begin
      owe(burst_drop, 1'b0, '0, 1'b0, held);
    end
  endfunction

  function automatic void check_result();
    buf_result_t got;
    buf_result_t want;
    got = {status, has_data, read_byte, last, fill_level};
    results_seen++;
    if (has_data) bytes_read++;
    if (status) rejects_seen++;
    if (owed_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result with none owed: st=%0d hd=%0d byte=%02h last=%0d fill=%0d",
                 $time, got.status, got.has_data, got.rbyte, got.last, got.fill);
      end
      return;
    end
    want = owed_results.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: mismatch exp st=%0d hd=%0d byte=%02h last=%0d fill=%0d",
                 $time, want.status, want.has_data, want.rbyte, want.last, want.fill);
        $display("%0t:          got st=%0d hd=%0d byte=%02h last=%0d fill=%0d",
                 $time, got.status, got.has_data, got.rbyte, got.last, got.fill);
      end
    end
  endfunction

  // Results first: they belong to items taken at earlier edges
  always @(posedge clk) begin
    if (rst) begin
      owed_results.delete();
      rd_ptr       = 0;
      held         = 0;
      burst_left   = 0;
      burst_off    = 0;
      burst_drop   = 1'b0;
      cap_reg      = CAP_RESET;
      mismatches   = 0;
      results_seen = 0;
      bytes_read   = 0;
      rejects_seen = 0;
    end else begin
      if (done) check_result();
      if (cfg_valid && cfg_ready) cap_reg = capacity;
      if (start && !busy) predict_buffer_item(op, burst_len, data_byte);
    end
    outstanding <= owed_results.size();
  end

endmodule

@@ bench/byte_ring_buffer_tb.sv @@
`timescale 1ns / 1ps

module byte_ring_buffer_tb;
  import brb_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 100;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  logic              op        = OP_WRITE;
  logic [LEN_W-1:0]  burst_len = '0;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              cfg_valid = 1'b0;
  logic [CNT_W-1:0]  capacity  = CAP_RESET;
  logic              busy;
  logic              cfg_ready;
  logic              done;
  logic              status;
  logic              has_data;
  logic [BYTE_W-1:0] read_byte;
  logic              last;
  logic [CNT_W-1:0]  fill_level;

  int mismatches;
  int outstanding;
  int results_seen;
  int bytes_read;
  int rejects_seen;

  // Coarse view of the buffer, just enough to keep traffic well formed
  int held_est;
  int cap_est;
  int items_sent;
  int cap_settings;
  bit idle_gaps;
  int quiet_cycles;

  always #HALF_PERIOD clk = ~clk;

  byte_ring_buffer DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .burst_len  (burst_len),
    .data_byte  (data_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .capacity   (capacity),
    .done       (done),
    .status     (status),
    .has_data   (has_data),
    .read_byte  (read_byte),
    .last       (last),
    .fill_level (fill_level)
  );

  brb_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .burst_len    (burst_len),
    .data_byte    (data_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .capacity     (capacity),
    .done         (done),
    .status       (status),
    .has_data     (has_data),
    .read_byte    (read_byte),
    .last         (last),
    .fill_level   (fill_level),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .bytes_read   (bytes_read),
    .rejects_seen (rejects_seen)
  );

  // Watchdog: too long without any transfer on any channel
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int lesser(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // One item transfer, with an optional idle burst ahead of it
  task automatic send_item(input logic o, input logic [LEN_W-1:0] len,
                           input logic [BYTE_W-1:0] d);
    if (idle_gaps && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    op        <= o;
    burst_len <= len;
    data_byte <= d;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Full write burst; op and length on the trailing bytes are noise
  task automatic write_burst(input int len);
    bit   dropped;
    logic noise_op;
    int   i;
    dropped = (len > MAX_BURST_DEF) || (len + held_est > cap_est);
    send_item(OP_WRITE, LEN_W'(len), BYTE_W'($urandom));
    for (i = 1; i < len; i++) begin
      noise_op = $urandom_range(0, 1);
      send_item(noise_op, LEN_W'($urandom), BYTE_W'($urandom));
    end
    if (!dropped) held_est += len;
  endtask

  task automatic read_request(input int len);
    send_item(OP_READ, LEN_W'(len), BYTE_W'($urandom));
    if (len != 0 && len <= MAX_BURST_DEF && len <= held_est) held_est -= len;
  endtask

  // Hold the sender until every owed result has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic empty_buffer();
    while (held_est > 0) read_request(lesser(held_est, MAX_BURST_DEF));
  endtask

  task automatic set_capacity(input logic [CNT_W-1:0] value);
    wait_drained();
    capacity  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_est = (value == 0) ? 1 : lesser(int'(value), DEPTH_DEF);
    cap_settings++;
  endtask

  // Mostly legal bursts and reads, with a share of rejects and empties
  task automatic random_traffic(input int n_items);
    int stop_at;
    int room;
    int len;
    int pick;
    logic noise_op;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      room = (cap_est > held_est) ? cap_est - held_est : 0;
      pick = $urandom_range(0, 99);
      if (pick < 50 && room > 0) begin
        // short bursts keep the transaction count up
        len = lesser(room, ($urandom_range(0, 3) == 0) ? MAX_BURST_DEF : 8);
        write_burst($urandom_range(1, len));
      end else if (pick < 85 && held_est > 0) begin
        len = lesser(held_est, MAX_BURST_DEF);
        if ($urandom_range(0, 7) != 0) len = $urandom_range(1, len);
        read_request(len);
      end else if (pick < 90) begin
        noise_op = $urandom_range(0, 1);
        send_item(noise_op, '0, BYTE_W'($urandom));
      end else if (pick < 96) begin
        // read for more than is held, or longer than any burst
        read_request($urandom_range(lesser(held_est + 1, 127), 127));
      end else if (room < MAX_BURST_DEF) begin
        // write that does not fit
        write_burst($urandom_range(room + 1, MAX_BURST_DEF));
      end else begin
        write_burst(1);
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] pattern [8];
    logic noise_op;
    int i;
    pattern = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
    held_est     = 0;
    cap_est      = DEPTH_DEF;
    items_sent   = 0;
    cap_settings = 1;
    idle_gaps    = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty requests, rejects on an empty buffer
    send_item(OP_WRITE, '0, 8'hFF);
    send_item(OP_READ, '0, 8'h00);
    read_request(1);
    read_request(127);

    // Eight known bytes, with op flipping on the trailing items
    for (i = 0; i < 8; i++) begin
      noise_op = i[0];
      send_item((i == 0) ? OP_WRITE : noise_op, (i == 0) ? LEN_W'(8) : LEN_W'(7'h7F - i),
                pattern[i]);
    end
    held_est = 8;

    // Shrink below the fill while data is held: fill stays readable, a write overflows until it is read
    set_capacity(11'd3);
    write_burst(1);
    read_request(8);
    write_burst(3);
    read_request(3);

    // Random phases, each under its own capacity
    idle_gaps = 1'b1;
    set_capacity(11'd2047);
    random_traffic(15);
    write_burst(MAX_BURST_DEF + 1);
    empty_buffer();
    set_capacity(11'd1);
    random_traffic(8);
    empty_buffer();
    set_capacity(11'd0);
    random_traffic(8);
    empty_buffer();
    set_capacity(11'd5);
    random_traffic(8);
    empty_buffer();
    set_capacity(11'd64);
    random_traffic(12);
    empty_buffer();
    set_capacity(CNT_W'($urandom_range(2, DEPTH_DEF)));
    random_traffic(12);
    empty_buffer();
    set_capacity(11'd1024);

    // Back to back to the end
    idle_gaps = 1'b0;
    random_traffic(12);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d items, %0d results (%0d bytes read, %0d rejected).",
             items_sent, results_seen, bytes_read, rejects_seen);
    $display("Went through %0d capacity settings with empty, overflow and over-long requests.",
             cap_settings);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
